[design/sorted_priority_queue_top_macros.svh]
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq: same-cycle check failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq: next-cycle check failed");
`else
`define SPQ_ASSERT_NOW(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEF_CAPACITY = 128;
  localparam int VAL_W        = 32;
  localparam int OCC_W        = 8;
  localparam int STAT_W       = 2;
  localparam int OUT_DATA_W   = 48;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] new_val;
  } spq_ctrl_t;

endpackage

[design/spq_cell.sv]
// One storage cell of the shift-register priority queue.
module spq_cell import spq_pkg::*; (
  input  logic             clk,
  input  spq_ctrl_t        ctrl,
  input  logic             occ_self,   // this slot holds a live entry
  input  logic             ge_left,    // left neighbor stays ahead of the new value
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val,
  output logic             ge_self
);

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;

  always_comb begin
    // Equal stored values stay ahead, giving FIFO order among ties.
    ge_self   = occ_self && !($signed(ctrl.new_val) > $signed(value_r));
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (!ge_self) begin
        value_nxt = ge_left ? ctrl.new_val : left_val;
      end
    end else if (ctrl.rem) begin
      value_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign val = value_r;

endmodule

[design/sorted_priority_queue_top.sv]
// Top level: max-first priority queue built from a chain of compare/shift cells.
// Each result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one operation per cycle while the output is taken; every cell compares and shifts in parallel.
// The output register frees as it is taken, so input and output overlap.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid;
// cell contents are not cleared, the entry count alone marks live slots.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // [31:0] data_value
  input  logic                  in_tuser,   // [0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] removed_value, [33:32] status,
                                            // [41:34] occupancy, [47:42] zero
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [OCC_W-1:0]  out_occ_r;

  logic              accept, full, empty;
  spq_ctrl_t         ctrl;

  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic              cell_ge  [CAPACITY];
  logic              cell_occ [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CAP_CNT);
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.ins     = accept && (in_tuser == OP_INSERT) && !full;
    ctrl.rem     = accept && (in_tuser == OP_REMOVE) && !empty;
    ctrl.new_val = in_tdata;

    count_nxt    = count_r;
    out_val_nxt  = '0;
    out_stat_nxt = ST_DONE;
    if (in_tuser == OP_INSERT) begin
      if (full) begin
        out_stat_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        out_stat_nxt = ST_EMPTY;
      end else begin
        out_val_nxt = cell_val[0];
        count_nxt   = count_r - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    assign cell_occ[i] = (IDX < count_r);

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ_self  (cell_occ[i]),
      .ge_left   ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
      .left_val  (cell_val[(i == 0) ? 0 : i - 1]),
      .right_val (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .val       (cell_val[i]),
      .ge_self   (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_val_r  <= out_val_nxt;
      out_stat_r <= out_stat_nxt;
      out_occ_r  <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_occ_r, out_stat_r, out_val_r};

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_CNT)
  `SPQ_ASSERT_NOW(a_head_ordered, count_r >= CW'(2), !($signed(cell_val[1]) > $signed(cell_val[0])))
  `SPQ_ASSERT_NEXT(a_full_drop, accept && (in_tuser == OP_INSERT) && full, $stable(count_r) && (out_stat_r == ST_FULL))
  `SPQ_ASSERT_NEXT(a_empty_remove, accept && (in_tuser == OP_REMOVE) && empty, out_tvalid && (out_stat_r == ST_EMPTY) && (out_val_r == '0))

endmodule
